// ===== hdl/fifo_elevator_controller_macros.svh =====
// Assertion macros used by the elevator controller top level.
`ifndef FIFO_ELEVATOR_CONTROLLER_MACROS_SVH
`define FIFO_ELEVATOR_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define FEC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define FEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/fec_pkg.sv =====
// Shared types and constants for the FIFO elevator controller.
`default_nettype none

package fec_pkg;

	// Fixed field widths
	localparam int FLOOR_W    = 6;
	localparam int DWELL_W    = 16;
	localparam int COUNT_W    = 7;
	localparam int RES_W      = 3;
	localparam int DOOR_W     = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	// Item opcodes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Car motion codes
	typedef enum logic [1:0] {
		MOT_IDLE = 2'd0,
		MOT_UP   = 2'd1,
		MOT_DOWN = 2'd2,
		MOT_DOOR = 2'd3
	} motion_t;

	// Request result codes
	localparam logic [RES_W-1:0] RES_ADDED        = 3'd0;
	localparam logic [RES_W-1:0] RES_CANCELLED    = 3'd1;
	localparam logic [RES_W-1:0] RES_SAME_FLOOR   = 3'd2;
	localparam logic [RES_W-1:0] RES_OUT_OF_RANGE = 3'd3;
	localparam logic [RES_W-1:0] RES_TICK         = 3'd4;

	// Door event codes
	localparam logic [DOOR_W-1:0] DOOR_NONE   = 2'd0;
	localparam logic [DOOR_W-1:0] DOOR_OPENED = 2'd1;
	localparam logic [DOOR_W-1:0] DOOR_CLOSED = 2'd2;

	// Register indexes and reset values
	localparam logic [CFG_ADDR_W-1:0] CFG_LOWEST  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_HIGHEST = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_DWELL   = 2'd2;
	localparam logic [FLOOR_W-1:0]    LOWEST_RST  = 6'd0;
	localparam logic [FLOOR_W-1:0]    HIGHEST_RST = 6'd63;
	localparam logic [DWELL_W-1:0]    DWELL_RST   = 16'd5;

	// Input item
	typedef struct packed {
		logic               op;
		logic [FLOOR_W-1:0] floor;
	} item_t;

	// Result item
	typedef struct packed {
		logic [FLOOR_W-1:0] current_floor;
		motion_t            motion;
		logic [FLOOR_W-1:0] target_floor;
		logic [COUNT_W-1:0] pending_count;
		logic [RES_W-1:0]   request_result;
		logic [DOOR_W-1:0]  door_event;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic pass_start;
		logic pass_run;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_pass;
		logic pass_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/fec_ctrl.sv =====
// Sequencing state machine and result handshake for the elevator controller.
`default_nettype none

module fec_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	input  wire fec_pkg::dp_stat_t    stat,
	output fec_pkg::ctrl_cmd_t        cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EVAL   = 4'b0010,
		S_PASS   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q;
	logic   slot_free;

	// Output register may be refilled once it is empty or being taken
	assign slot_free = !result_valid_q || result_ready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.need_pass) begin
					cmd.pass_start = 1'b1;
					state_d        = S_PASS;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_PASS: begin
				cmd.pass_run = 1'b1;
				if (stat.pass_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

// ===== hdl/fec_dp.sv =====
// Datapath: registers, pending-floor queue memory and car state update.
`default_nettype none

module fec_dp #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fec_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [fec_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire fec_pkg::item_t                     item_data,
	input  wire fec_pkg::ctrl_cmd_t                 cmd,
	output fec_pkg::dp_stat_t                       stat,
	output fec_pkg::result_t                        result_data
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int FW = fec_pkg::FLOOR_W;
	localparam int DW = fec_pkg::DWELL_W;

	// Configuration
	logic [FW-1:0] lowest_q, highest_q;
	logic [DW-1:0] dwell_cfg_q;

	// Latched item
	logic          op_q;
	logic [FW-1:0] key_q;

	// Car state
	logic [FW-1:0]    car_q, serving_q, head_q;
	fec_pkg::motion_t motion_q;
	logic [DW-1:0]    dwell_q;
	logic [CW-1:0]    total_q;

	// Queue memory and pass pipeline
	logic [FW-1:0] mem [QUEUE_DEPTH];
	logic [CW-1:0] rd_ptr_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [FW-1:0] rd_data_s1;
	logic          found_q, found_head_q;

	fec_pkg::result_t result_q;

	// Item decode
	logic          moving, arrive, same_floor, out_range, pass_head;
	logic [FW-1:0] step_car;

	// Pass control
	logic          issue, match, shift_wr, head_upd;
	logic [AW-1:0] wr_pos, place;

	// Memory write port
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [FW-1:0] wr_data;

	// Commit values
	logic [FW-1:0]                car_d, serving_d, head_nx;
	fec_pkg::motion_t             motion_d;
	logic [DW-1:0]                dwell_d;
	logic [CW-1:0]                total_d;
	logic [fec_pkg::RES_W-1:0]    res_d;
	logic [fec_pkg::DOOR_W-1:0]   door_d;
	logic                         app_we, pick;
	logic [31:0]                  total_ext;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_q    <= fec_pkg::LOWEST_RST;
			highest_q   <= fec_pkg::HIGHEST_RST;
			dwell_cfg_q <= fec_pkg::DWELL_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				fec_pkg::CFG_LOWEST:  lowest_q    <= cfg_wdata[FW-1:0];
				fec_pkg::CFG_HIGHEST: highest_q   <= cfg_wdata[FW-1:0];
				fec_pkg::CFG_DWELL:   dwell_cfg_q <= cfg_wdata[DW-1:0];
				default: ;
			endcase
		end
	end

	// Item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= item_data.op;
			key_q <= item_data.floor;
		end
	end

	// One-floor step toward the target and arrival check
	always_comb begin
		step_car = car_q;
		if (motion_q == fec_pkg::MOT_UP && car_q < serving_q) begin
			step_car = car_q + FW'(1);
		end else if (motion_q == fec_pkg::MOT_DOWN && car_q > serving_q) begin
			step_car = car_q - FW'(1);
		end
	end

	assign moving     = (motion_q == fec_pkg::MOT_UP) || (motion_q == fec_pkg::MOT_DOWN);
	assign arrive     = moving && (step_car == serving_q);
	assign same_floor = (key_q == car_q);
	assign out_range  = (lowest_q > highest_q) || (key_q < lowest_q) || (key_q > highest_q);
	assign pass_head  = (op_q == fec_pkg::OP_TICK);

	// A request in range and not for the car's floor searches the queue; an arrival drops the head
	assign stat.need_pass = (op_q == fec_pkg::OP_REQUEST) ? (!same_floor && !out_range) : arrive;
	assign stat.pass_done = (rd_ptr_q >= total_q) && !rd_vld_s1;

	// Removal pass: read one entry a cycle, move later entries down by one
	assign issue    = cmd.pass_run && (rd_ptr_q < total_q);
	assign match    = rd_vld_s1 && !found_q &&
	                  (pass_head ? (rd_idx_s1 == '0) : (rd_data_s1 == key_q));
	assign shift_wr = rd_vld_s1 && found_q;
	assign wr_pos   = rd_idx_s1 - AW'(1);
	assign place    = found_q ? wr_pos : rd_idx_s1;
	assign head_upd = rd_vld_s1 && !match && (place == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q     <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			found_head_q <= 1'b0;
		end else if (cmd.pass_start) begin
			rd_ptr_q     <= '0;
			rd_vld_s1    <= 1'b0;
			found_q      <= 1'b0;
			found_head_q <= 1'b0;
		end else begin
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + CW'(1);
			end
			rd_vld_s1 <= issue;
			if (match) begin
				found_q      <= 1'b1;
				found_head_q <= (rd_idx_s1 == '0);
			end
		end
	end

	// Memory write port: pass shifts, or append on commit
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_pos;
		wr_data = rd_data_s1;
		if (shift_wr) begin
			wr_en = 1'b1;
		end else if (app_we) begin
			wr_en   = 1'b1;
			wr_addr = total_q[AW-1:0];
			wr_data = key_q;
		end
	end

	// Queue memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_ptr_q[AW-1:0]];
			rd_idx_s1  <= rd_ptr_q[AW-1:0];
		end
	end

	// Copy of the queue head
	always_ff @(posedge clk) begin
		if (head_upd) begin
			head_q <= rd_data_s1;
		end else if (app_we && total_q == '0) begin
			head_q <= key_q;
		end
	end

	// Next car state for the item being committed
	always_comb begin
		car_d     = car_q;
		serving_d = serving_q;
		motion_d  = motion_q;
		dwell_d   = dwell_q;
		total_d   = total_q;
		res_d     = fec_pkg::RES_TICK;
		door_d    = fec_pkg::DOOR_NONE;
		app_we    = 1'b0;
		pick      = 1'b0;
		head_nx   = (total_q == '0) ? key_q : head_q;
		if (op_q == fec_pkg::OP_REQUEST) begin
			if (same_floor) begin
				res_d = fec_pkg::RES_SAME_FLOOR;
			end else if (out_range) begin
				res_d = fec_pkg::RES_OUT_OF_RANGE;
			end else if (found_q) begin
				res_d   = fec_pkg::RES_CANCELLED;
				total_d = total_q - CW'(1);
				pick    = found_head_q && moving;
			end else if (total_q >= CW'(QUEUE_DEPTH)) begin
				res_d = fec_pkg::RES_OUT_OF_RANGE;
			end else begin
				res_d   = fec_pkg::RES_ADDED;
				total_d = total_q + CW'(1);
				app_we  = cmd.commit;
				pick    = (motion_q == fec_pkg::MOT_IDLE);
			end
		end else if (moving) begin
			car_d = step_car;
			if (arrive) begin
				if (found_q) begin
					total_d = total_q - CW'(1);
				end
				motion_d = fec_pkg::MOT_DOOR;
				dwell_d  = (dwell_cfg_q == '0) ? DW'(1) : dwell_cfg_q;
				door_d   = fec_pkg::DOOR_OPENED;
			end
		end else if (motion_q == fec_pkg::MOT_DOOR) begin
			dwell_d = (dwell_q != '0) ? (dwell_q - DW'(1)) : '0;
			if (dwell_d == '0) begin
				door_d = fec_pkg::DOOR_CLOSED;
				pick   = 1'b1;
			end
		end
		// Choose the next target from the queue head
		if (pick) begin
			if (total_d == '0) begin
				motion_d  = fec_pkg::MOT_IDLE;
				serving_d = '0;
			end else begin
				serving_d = head_nx;
				motion_d  = (head_nx < car_d) ? fec_pkg::MOT_DOWN : fec_pkg::MOT_UP;
			end
		end
	end

	assign total_ext = 32'(total_d);

	// Car state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_q     <= '0;
			serving_q <= '0;
			motion_q  <= fec_pkg::MOT_IDLE;
			dwell_q   <= '0;
			total_q   <= '0;
		end else if (cmd.commit) begin
			car_q     <= car_d;
			serving_q <= serving_d;
			motion_q  <= motion_d;
			dwell_q   <= dwell_d;
			total_q   <= total_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q.current_floor  <= car_d;
			result_q.motion         <= motion_d;
			result_q.target_floor   <= (motion_d == fec_pkg::MOT_IDLE) ? '0 : serving_d;
			result_q.pending_count  <= total_ext[fec_pkg::COUNT_W-1:0];
			result_q.request_result <= res_d;
			result_q.door_event     <= door_d;
		end
	end

	assign result_data = result_q;

endmodule

`default_nettype wire

// ===== hdl/fifo_elevator_controller.sv =====
// Top level of the FIFO elevator controller: sequencer, datapath and checks.
//
//  channel  direction  signals                          item
//  item     in         item_valid/item_ready/item_data  request or tick
//  result   out        result_valid/result_ready/...    car status, one per item
//  config   in         cfg_we/cfg_addr/cfg_wdata        register write, no wait
//
// A request in range, or a tick that arrives, sweeps the queue memory through its single
// read port, one entry a cycle; other items need no sweep. Reset clears all control
// state; the queue needs no clearing.
// A stalled result holds in the output register while the next item is taken;
// that item waits for the register to free before it commits.
`default_nettype none

`include "fifo_elevator_controller_macros.svh"

module fifo_elevator_controller #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire fec_pkg::item_t                 item_data,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output fec_pkg::result_t                    result_data,
	input  wire logic                           cfg_we,
	input  wire logic [fec_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [fec_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	fec_pkg::ctrl_cmd_t ctrl_cmd;
	fec_pkg::dp_stat_t  dp_stat;

	// Sequencer
	fec_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (dp_stat),
		.cmd          (ctrl_cmd)
	);

	// Datapath
	fec_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.item_data   (item_data),
		.cmd         (ctrl_cmd),
		.stat        (dp_stat),
		.result_data (result_data)
	);

	// Checks
	`FEC_ASSERT_NEXT(a_one_item_at_a_time, item_valid && item_ready, !item_ready, "second item taken during work")
	`FEC_ASSERT_IMP(a_commit_into_free_slot, ctrl_cmd.commit, !result_valid || result_ready, "result overwritten")
	`FEC_ASSERT_IMP(a_idle_means_empty, result_valid && result_data.motion == fec_pkg::MOT_IDLE, result_data.target_floor == '0 && result_data.pending_count == '0, "idle car with work")
	`FEC_ASSERT_IMP(a_door_opens_on_tick, result_valid && result_data.door_event == fec_pkg::DOOR_OPENED, result_data.motion == fec_pkg::MOT_DOOR && result_data.request_result == fec_pkg::RES_TICK, "door opened outside a tick")

endmodule

`default_nettype wire
